@@ sv/ptw_pkg.sv @@
// shared types, constants and address helpers for the page table walker
`timescale 1ns / 1ps

package ptw_pkg;

   // table memory geometry, a whole number of 512-entry tables
   localparam int TABLE_WORDS  = 4096;
   localparam int TABLE_AW     = $clog2(TABLE_WORDS);
   localparam int TABLE_FRAMES = TABLE_WORDS / 512;

   localparam int ENTRY_W = 64;
   localparam int IDX_W   = 9;
   localparam int FRAME_W = 40;
   localparam int FULL_W  = FRAME_W + IDX_W;
   localparam int PA_W    = 52;
   localparam int VA_W    = 48;
   localparam int WIDX_W  = 12;

   // entry bit positions
   localparam int BIT_P  = 0;
   localparam int BIT_RW = 1;
   localparam int BIT_US = 2;
   localparam int BIT_PS = 7;
   localparam int BIT_XD = 63;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_XLATE = 1'b1;

   localparam logic [1:0] PAGE_4K = 2'd0;
   localparam logic [1:0] PAGE_2M = 2'd1;
   localparam logic [1:0] PAGE_1G = 2'd2;

   localparam logic [1:0] LVL_PML4 = 2'd0;
   localparam logic [1:0] LVL_PDPT = 2'd1;
   localparam logic [1:0] LVL_PD   = 2'd2;
   localparam logic [1:0] LVL_PT   = 2'd3;

   typedef struct packed {
      logic                in_range;
      logic [TABLE_AW-1:0] addr;
   } word_ref_type;

   typedef struct packed {
      logic                wr_en;
      logic [TABLE_AW-1:0] wr_addr;
      logic [ENTRY_W-1:0]  wr_data;
      logic                rd_en;
      logic [TABLE_AW-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [PA_W-1:0] xlat_pa;
      logic            fault;
      logic [1:0]      map_size;
      logic            can_write;
      logic            user_access;
      logic            can_execute;
   } result_type;

   // nine index bits of the virtual address for one level
   function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                 input logic [1:0] level);
      logic [IDX_W-1:0] idx;
      case (level)
         LVL_PML4: idx = va[47:39];
         LVL_PDPT: idx = va[38:30];
         LVL_PD:   idx = va[29:21];
         default:  idx = va[20:12];
      endcase
      return idx;
   endfunction

   // word address of entry idx in the table at frame, with range check
   function automatic word_ref_type table_word(input logic [FRAME_W-1:0] frame,
                                               input logic [IDX_W-1:0] idx);
      logic [FULL_W-1:0] full;
      word_ref_type      ref_w;
      full = {frame, idx};
      ref_w.in_range = (frame < FRAME_W'(TABLE_FRAMES));
      ref_w.addr     = full[TABLE_AW-1:0];
      return ref_w;
   endfunction

endpackage

@@ sv/ptw_ram.sv @@
// generic single-clock ram with one write port and a registered read port
`timescale 1ns / 1ps

module ptw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ptw_walker.sv @@
// walk sequencer: table clearing, table writes and the four-level walk
`timescale 1ns / 1ps

module ptw_walker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_action,
   input  logic [ptw_pkg::WIDX_W-1:0]          req_word_index,
   input  logic [ptw_pkg::ENTRY_W-1:0]         req_write_data,
   input  logic [ptw_pkg::VA_W-1:0]            req_lookup_va,
   input  logic [ptw_pkg::PA_W-1:0]            root_base,
   input  logic                                out_free,
   output logic                                res_valid,
   output ptw_pkg::result_type                 res,
   output ptw_pkg::mem_req_type                mem,
   input  logic [ptw_pkg::ENTRY_W-1:0]         rd_data
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK} state_type;

   state_type                       state_ff, state_in;
   logic [1:0]                      level_ff, level_in;
   logic [ptw_pkg::VA_W-1:0]        va_ff, va_in;
   logic                            oor_ff, oor_in;
   logic [ptw_pkg::TABLE_AW-1:0]    clear_addr_ff, clear_addr_in;

   logic                            accept;
   logic [ptw_pkg::ENTRY_W-1:0]     entry;
   logic                            present;
   logic                            huge;
   logic                            leaf;
   logic                            finish;
   ptw_pkg::word_ref_type           root_word;
   ptw_pkg::word_ref_type           next_word;
   logic [ptw_pkg::FULL_W-1:0]      wr_full;
   ptw_pkg::result_type             walk_res;

   always_comb begin
      accept = req_tvalid && req_tready;
      // a read past the end of the table never reached the ram
      entry = oor_ff ? '0 : rd_data;
      present = entry[ptw_pkg::BIT_P];
      huge = entry[ptw_pkg::BIT_PS];
      leaf = (level_ff == ptw_pkg::LVL_PT) ||
             (huge && ((level_ff == ptw_pkg::LVL_PDPT) || (level_ff == ptw_pkg::LVL_PD)));
      finish = !present || leaf;
      root_word = ptw_pkg::table_word(root_base[51:12],
                                      ptw_pkg::va_index(req_lookup_va, ptw_pkg::LVL_PML4));
      next_word = ptw_pkg::table_word(entry[51:12],
                                      ptw_pkg::va_index(va_ff, 2'(level_ff + 2'd1)));
      wr_full = ptw_pkg::FULL_W'(req_word_index);

      walk_res = '0;
      if (!present) begin
         walk_res.fault = 1'b1;
      end else begin
         case (level_ff)
            ptw_pkg::LVL_PDPT: begin
               walk_res.xlat_pa  = {entry[51:30], va_ff[29:0]};
               walk_res.map_size = ptw_pkg::PAGE_1G;
            end
            ptw_pkg::LVL_PD: begin
               walk_res.xlat_pa  = {entry[51:21], va_ff[20:0]};
               walk_res.map_size = ptw_pkg::PAGE_2M;
            end
            default: begin
               walk_res.xlat_pa  = {entry[51:12], va_ff[11:0]};
               walk_res.map_size = ptw_pkg::PAGE_4K;
            end
         endcase
         walk_res.can_write   = entry[ptw_pkg::BIT_RW];
         walk_res.user_access = entry[ptw_pkg::BIT_US];
         walk_res.can_execute = !entry[ptw_pkg::BIT_XD];
      end
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      va_in         = va_ff;
      oor_in        = oor_ff;
      clear_addr_in = clear_addr_ff;
      mem           = '0;
      res_valid     = 1'b0;
      res           = '0;
      req_tready    = (state_ff == ST_IDLE) && out_free;

      case (state_ff)
         ST_CLEAR: begin
            mem.wr_en     = 1'b1;
            mem.wr_addr   = clear_addr_ff;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ptw_pkg::TABLE_AW'(ptw_pkg::TABLE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ptw_pkg::ACT_WRITE) begin
                  mem.wr_en   = (wr_full < ptw_pkg::FULL_W'(ptw_pkg::TABLE_WORDS));
                  mem.wr_addr = wr_full[ptw_pkg::TABLE_AW-1:0];
                  mem.wr_data = req_write_data;
                  res_valid   = 1'b1;
               end else begin
                  va_in       = req_lookup_va;
                  level_in    = ptw_pkg::LVL_PML4;
                  oor_in      = !root_word.in_range;
                  mem.rd_en   = root_word.in_range;
                  mem.rd_addr = root_word.addr;
                  state_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (finish) begin
               // hold here with read data parked until the result slot frees
               if (out_free) begin
                  res_valid = 1'b1;
                  res       = walk_res;
                  state_in  = ST_IDLE;
               end
            end else begin
               level_in    = 2'(level_ff + 2'd1);
               oor_in      = !next_word.in_range;
               mem.rd_en   = next_word.in_range;
               mem.rd_addr = next_word.addr;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         level_ff      <= '0;
         oor_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         level_ff      <= level_in;
         oor_ff        <= oor_in;
      end
      va_ff <= va_in;
   end

   a_res_slot_free: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result produced while output slot is occupied");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem.wr_en && mem.rd_en))
      else $error("table ram read and written in the same cycle");

   a_xlate_walks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ptw_pkg::ACT_XLATE) |=> (state_ff == ST_WALK))
      else $error("accepted translation did not start a walk");

   a_no_level_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && !finish) |-> (level_ff != ptw_pkg::LVL_PT))
      else $error("walk continued past the last level");

   a_walk_level_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && !finish) |=> (level_ff == 2'($past(level_ff) + 2'd1)))
      else $error("walk level did not advance by one");

endmodule

@@ sv/four_level_page_table_walker_core.sv @@
// Four-level page table walker with a local 4096 x 64 table ram (TABLE_WORDS
// in ptw_pkg). After reset the block sweeps the ram to zero, one word per
// cycle, and accepts no transaction until it is done; root_base writes are
// taken at any time. A translation visits one level per dependent read of the
// single table ram, which has a registered read port, and stops at the first
// level whose entry is not present or is a leaf (4 KiB, 2 MiB or 1 GiB page).
// Each result is held in an output register; while it waits on rsp_tready no
// new transaction is taken, so rsp stalls delay later transactions.
`timescale 1ns / 1ps

module four_level_page_table_walker_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // word_index [11:0], write_data [75:12], lookup_va [123:76], zero [127:124]
   input  logic [127:0]                  req_tdata,
   // action
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // xlat_pa [51:0], map_size [53:52], can_write [54], user_access [55],
   // can_execute [56], zero [63:57]
   output logic [63:0]                   rsp_tdata,
   // fault
   output logic                          rsp_tuser,
   input  logic                          csr_wr_en,
   input  logic [ptw_pkg::PA_W-1:0]      csr_wr_data
);

   logic [ptw_pkg::PA_W-1:0]     root_ff, root_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ptw_pkg::result_type          rsp_res_ff, rsp_res_in;

   logic                         out_free;
   logic                         res_valid;
   ptw_pkg::result_type          res;
   ptw_pkg::mem_req_type         mem;
   logic [ptw_pkg::ENTRY_W-1:0]  rd_data;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      root_in      = csr_wr_en ? csr_wr_data : root_ff;
      rsp_res_in   = res_valid ? res : rsp_res_ff;
      rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   ptw_walker u_walker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_action     (req_tuser),
      .req_word_index (req_tdata[11:0]),
      .req_write_data (req_tdata[75:12]),
      .req_lookup_va  (req_tdata[123:76]),
      .root_base      (root_ff),
      .out_free       (out_free),
      .res_valid      (res_valid),
      .res            (res),
      .mem            (mem),
      .rd_data        (rd_data)
   );

   ptw_ram #(
      .WIDTH (ptw_pkg::ENTRY_W),
      .DEPTH (ptw_pkg::TABLE_WORDS)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_res_ff.can_execute, rsp_res_ff.user_access,
                        rsp_res_ff.can_write, rsp_res_ff.map_size, rsp_res_ff.xlat_pa};
   assign rsp_tuser  = rsp_res_ff.fault;

endmodule

@@ dv/tb_four_level_page_table_walker_core.sv @@
// testbench for the four-level page table walker core
`timescale 1ns / 1ps

module tb_four_level_page_table_walker_core;

   import ptw_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DIR_ROWS       = 23;

   typedef struct {
      logic             action;
      logic [11:0]      word_index;
      logic [63:0]      write_data;
      logic [47:0]      lookup_va;
      logic             typed;
      result_type       exp;
   } pt_item_t;

   localparam result_type RES_NONE  = '{52'h0, 1'b0, PAGE_4K, 1'b0, 1'b0, 1'b0};
   localparam result_type RES_FAULT = '{52'h0, 1'b1, PAGE_4K, 1'b0, 1'b0, 1'b0};

   logic          clock;
   logic          reset       = 1'b1;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata   = '0;
   logic          req_tuser   = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [63:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          csr_wr_en   = 1'b0;
   logic [PA_W-1:0] csr_wr_data = '0;

   // shadow of the table ram and root register
   logic [63:0]   pt_mem [TABLE_WORDS];
   logic [51:0]   root_q = '0;
   result_type    xlate_q [$];

   int            mismatch_count = 0;
   int            stall_left     = 0;
   int            stalled_cycles = 0;
   logic          calm           = 1'b0;

   // directed walk: build a small hierarchy by hand and poke at its corners
   pt_item_t dir_rows [DIR_ROWS] = '{
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0000_0000_0000, 1'b1, RES_FAULT},
      '{ACT_XLATE, 12'h000, 64'h0, 48'hFFFF_FFFF_FFFF, 1'b1, RES_FAULT},
      '{ACT_WRITE, 12'h000, 64'h0000_0000_0000_1003, 48'h0, 1'b1, RES_NONE},
      // 1 GiB page with no-execute
      '{ACT_WRITE, 12'h200, 64'h8000_0000_4000_0087, 48'h0, 1'b1, RES_NONE},
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0000_3ABC_DEF0, 1'b0, RES_NONE},
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0000_0000_0000, 1'b0, RES_NONE},
      '{ACT_WRITE, 12'h201, 64'h0000_0000_0000_2001, 48'h0, 1'b1, RES_NONE},
      // 2 MiB page
      '{ACT_WRITE, 12'h400, 64'h0000_0000_0020_0083, 48'h0, 1'b1, RES_NONE},
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0000_401F_FFFF, 1'b0, RES_NONE},
      // junk in bits 62..52 must not reach the table address
      '{ACT_WRITE, 12'h401, 64'h7FF0_0000_0000_3007, 48'h0, 1'b1, RES_NONE},
      // all-ones pt entry, huge bit ignored at the last level
      '{ACT_WRITE, 12'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 1'b1, RES_NONE},
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0000_403F_FFFF, 1'b0, RES_NONE},
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0000_4020_0000, 1'b1, RES_FAULT},
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0000_40A0_0000, 1'b1, RES_FAULT},
      // huge bit in a pml4 entry is ignored
      '{ACT_WRITE, 12'h001, 64'h0000_0000_0000_1081, 48'h0, 1'b1, RES_NONE},
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0080_3ABC_DEF0, 1'b0, RES_NONE},
      // next table beyond the ram reads as not present
      '{ACT_WRITE, 12'h002, 64'h000F_FFFF_FFFF_F001, 48'h0, 1'b1, RES_NONE},
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0100_0000_0000, 1'b1, RES_FAULT},
      '{ACT_WRITE, 12'h003, 64'hFFFF_FFFF_FFFF_FFFE, 48'h0, 1'b1, RES_NONE},
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0180_0000_0000, 1'b1, RES_FAULT},
      '{ACT_WRITE, 12'hFFF, 64'h0000_0000_0000_0000, 48'h0, 1'b1, RES_NONE},
      '{ACT_WRITE, 12'h000, 64'h0000_0000_0000_0000, 48'h0, 1'b1, RES_NONE},
      '{ACT_XLATE, 12'h000, 64'h0, 48'h0000_3ABC_DEF0, 1'b1, RES_FAULT}
   };

   four_level_page_table_walker_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (pt_mem[i]) pt_mem[i] = '0;
   end

   // applies one transaction to the shadow tables and returns its translation
   function automatic result_type walk_tables(input pt_item_t it);
      result_type  res;
      logic [51:0] base;
      logic [63:0] ent;
      logic [48:0] widx;
      logic [8:0]  idx;
      res = '0;
      if (it.action == ACT_WRITE) begin
         if (int'(it.word_index) < TABLE_WORDS) pt_mem[it.word_index] = it.write_data;
         return res;
      end
      base = root_q;
      for (int lvl = LVL_PML4; lvl <= LVL_PT; lvl++) begin
         idx  = it.lookup_va[47 - 9*lvl -: 9];
         widx = {base[51:12], idx};
         ent  = (widx < TABLE_WORDS) ? pt_mem[widx[TABLE_AW-1:0]] : 64'h0;
         if (!ent[BIT_P]) begin
            res.fault = 1'b1;
            return res;
         end
         if (lvl == LVL_PT || (ent[BIT_PS] && lvl != LVL_PML4)) begin
            res.can_write   = ent[BIT_RW];
            res.user_access = ent[BIT_US];
            res.can_execute = !ent[BIT_XD];
            case (lvl)
               LVL_PDPT: begin
                  res.map_size = PAGE_1G;
                  res.xlat_pa  = {ent[51:30], it.lookup_va[29:0]};
               end
               LVL_PD: begin
                  res.map_size = PAGE_2M;
                  res.xlat_pa  = {ent[51:21], it.lookup_va[20:0]};
               end
               default: begin
                  res.map_size = PAGE_4K;
                  res.xlat_pa  = {ent[51:12], it.lookup_va[11:0]};
               end
            endcase
            return res;
         end
         base = ent[51:0];
      end
      return res;
   endfunction

   function automatic logic [63:0] make_entry(input logic [39:0] frame, input logic huge,
                                              input logic present);
      logic [63:0] ent;
      ent = {$urandom, $urandom};
      ent[51:12]  = frame;
      ent[BIT_PS] = huge;
      ent[BIT_P]  = present;
      return ent;
   endfunction

   function automatic pt_item_t write_item(input logic [11:0] widx, input logic [63:0] data);
      pt_item_t it;
      it = '{ACT_WRITE, widx, data, 48'h0, 1'b0, RES_NONE};
      return it;
   endfunction

   function automatic pt_item_t xlate_item(input logic [47:0] va);
      pt_item_t it;
      it = '{ACT_XLATE, 12'h0, 64'h0, va, 1'b0, RES_NONE};
      return it;
   endfunction

   task automatic send_item(input pt_item_t it);
      result_type predicted;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {4'b0, it.lookup_va, it.write_data, it.word_index};
      do @(posedge clock); while (!req_tready);
      predicted = walk_tables(it);
      xlate_q.push_back(it.typed ? it.exp : predicted);
   endtask

   task automatic set_root(input logic [51:0] value);
      while (xlate_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      root_q = value;
   endtask

   // mostly complete mappings followed by lookups in them, plus random noise
   task automatic run_phase(input int n_items);
      pt_item_t    batch [$];
      logic [63:0] rnd;
      logic [47:0] va;
      logic [47:0] mask;
      logic [39:0] frame;
      logic [39:0] next_frame;
      logic        huge;
      int          leaf_lvl;
      int          sent;
      sent = 0;
      while (sent < n_items) begin
         batch.delete();
         if (root_q[51:12] < TABLE_FRAMES && $urandom_range(0, 9) < 8) begin
            rnd      = {$urandom, $urandom};
            va       = rnd[47:0];
            leaf_lvl = $urandom_range(LVL_PDPT, LVL_PT);
            frame    = root_q[51:12];
            for (int lvl = LVL_PML4; lvl <= leaf_lvl; lvl++) begin
               if (frame >= TABLE_FRAMES) break;
               rnd = {$urandom, $urandom};
               if (lvl == leaf_lvl || $urandom_range(0, 15) == 0)
                  next_frame = rnd[39:0];
               else
                  next_frame = 40'($urandom_range(0, TABLE_FRAMES - 1));
               if (lvl == leaf_lvl)
                  huge = (lvl == LVL_PT) ? 1'($urandom) : 1'b1;
               else
                  huge = (lvl == LVL_PML4) ? 1'($urandom) : 1'b0;
               batch.push_back(write_item(12'({frame, va[47 - 9*lvl -: 9]}),
                                          make_entry(next_frame, huge,
                                                     $urandom_range(0, 24) != 0)));
               frame = next_frame;
            end
            batch.push_back(xlate_item(va));
            repeat ($urandom_range(0, 2)) begin
               rnd  = {$urandom, $urandom};
               mask = (48'h1 << (12 + 9 * $urandom_range(0, 3))) - 48'h1;
               batch.push_back(xlate_item(va ^ (rnd[47:0] & mask)));
            end
         end else begin
            rnd = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0)
               batch.push_back(write_item(12'($urandom), rnd));
            else
               batch.push_back(xlate_item(rnd[47:0]));
         end
         foreach (batch[i]) send_item(batch[i]);
         sent += batch.size();
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin : main
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) send_item(dir_rows[i]);
      req_tvalid <= 1'b0;

      // unaligned root, low bits must be dropped
      set_root(52'h0_0000_0000_2ABC);
      run_phase(450);
      // root far outside the ram, every lookup faults
      set_root({PA_W{1'b1}});
      run_phase(150);
      set_root({40'($urandom_range(0, TABLE_FRAMES - 1)), 12'($urandom)});
      run_phase(500);
      set_root(52'h0);
      run_phase(350);
      set_root({40'($urandom_range(0, TABLE_FRAMES - 1)), 12'h000});
      calm = 1'b1;
      run_phase(450);

      while (xlate_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   always @(posedge clock) begin : rsp_backpressure
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_checker
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.xlat_pa     = rsp_tdata[51:0];
         got.map_size    = rsp_tdata[53:52];
         got.can_write   = rsp_tdata[54];
         got.user_access = rsp_tdata[55];
         got.can_execute = rsp_tdata[56];
         got.fault       = rsp_tuser;
         if (xlate_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: pa=%h fault=%b size=%0d w=%b u=%b x=%b",
                        got.xlat_pa, got.fault, got.map_size, got.can_write,
                        got.user_access, got.can_execute);
         end else begin
            want = xlate_q.pop_front();
            if (got.xlat_pa !== want.xlat_pa || got.fault !== want.fault ||
                got.map_size !== want.map_size || got.can_write !== want.can_write ||
                got.user_access !== want.user_access ||
                got.can_execute !== want.can_execute) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected pa=%h fault=%b size=%0d w=%b u=%b x=%b, ",
                            "got pa=%h fault=%b size=%0d w=%b u=%b x=%b"},
                           want.xlat_pa, want.fault, want.map_size, want.can_write,
                           want.user_access, want.can_execute,
                           got.xlat_pa, got.fault, got.map_size, got.can_write,
                           got.user_access, got.can_execute);
            end
         end
      end
   end

   // covers the ram clearing sweep after reset with plenty of margin
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

endmodule
